// ----- hw/rtl/mept_pkg.sv -----
// Package for the multi-turn encoder position tracker: constants, codes and types.
`default_nettype none

package mept_pkg;

    // Tracked motors and the index width fixed by the input field.
    localparam int MOTORS     = 4;
    localparam int MOT_W      = 2;

    // Field widths.
    localparam int SAMPLE_W   = 12;
    localparam int TURN_W     = 16;
    localparam int TARGET_W   = 28;
    localparam int SPEED_W    = 12;
    localparam int RPM_W      = 12;
    localparam int STEPS_W    = 16;
    localparam int GEAR_W     = 16;
    localparam int USTEP_W    = 16;
    localparam int GAIN_W     = 9;

    // Encoder geometry: counts per turn is a power of two.
    localparam int CPT_LOG2   = 12;
    localparam int CPT        = 1 << CPT_LOG2;
    localparam int CPT_HALF   = CPT / 2;

    // Per-motor state word: turn count over last sample.
    localparam int STATE_W    = TURN_W + SAMPLE_W;

    // Move arithmetic widths.
    localparam int POS_W      = 30;
    localparam int TPROD_W    = 45;
    localparam int DIFF_W     = 46;
    localparam int ADIFF_W    = 45;
    localparam int LO_W       = 23;
    localparam int HI_W       = ADIFF_W - LO_W;
    localparam int PLO_W      = LO_W + USTEP_W;
    localparam int PHI_W      = HI_W + USTEP_W;
    localparam int PSUM_W     = ADIFF_W + USTEP_W;
    localparam int STEP_SHIFT = CPT_LOG2 + 8;
    localparam int Q_W        = PSUM_W - STEP_SHIFT;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Command codes.
    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_TARGET = 1'b1
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GEAR     = 3'd0,
        CFG_USTEPS   = 3'd1,
        CFG_RPM_GAIN = 3'd2,
        CFG_ZOFF_M0  = 3'd3,
        CFG_ZOFF_M1  = 3'd4,
        CFG_ZOFF_M2  = 3'd5,
        CFG_ZOFF_M3  = 3'd6
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/mept_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mept_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- hw/rtl/multiturn_encoder_position_tracker_core.sv -----
// Top level of the multi-turn encoder position tracker.
//
//  Channel   Direction  Handshake                   Word
//  input     in         i_in_valid / o_in_stall     command, motor, sample, target
//  output    out        o_out_valid / i_out_stall   motor, turns, speed, rpm, move
//  config    in         i_cfg_wr_en                 register index and data
//
// Set-target words and seeding ticks are handled in ST_IDLE. A tick without a
// pending target passes ST_READ, ST_DIFF and ST_OUT; one with a pending target also
// passes ST_MUL_LO and ST_MUL_HI for the two partial products of the step count.
// Reset is synchronous; it clears the seeded and pending flags, the state and the
// output valid, and loads the configuration defaults. A waiting result does not
// block a new input word; only finishing the next tick waits on a stalled output.
`default_nettype none

module multiturn_encoder_position_tracker_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Input channel.
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic                                  i_command,
    input  wire logic [mept_pkg::MOT_W-1:0]            i_motor_index,
    input  wire logic [mept_pkg::SAMPLE_W-1:0]         i_encoder_sample,
    input  wire logic signed [mept_pkg::TARGET_W-1:0]  i_target_position,
    // Output channel.
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic      [mept_pkg::MOT_W-1:0]            o_motor_index_out,
    output logic signed [mept_pkg::TURN_W-1:0]         o_turn_count_out,
    output logic      [mept_pkg::SPEED_W-1:0]          o_speed_counts,
    output logic      [mept_pkg::RPM_W-1:0]            o_rpm_estimate,
    output logic                                       o_move_valid,
    output logic                                       o_move_reverse,
    output logic      [mept_pkg::STEPS_W-1:0]          o_move_steps,
    // Configuration port.
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [mept_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [mept_pkg::CFG_DATA_W-1:0]       i_cfg_wr_data
);

    // ------------------------------------------------------------------
    // Declarations.
    // ------------------------------------------------------------------
    mept_pkg::t_state r_state, n_state;

    logic [mept_pkg::GEAR_W-1:0]   r_gear;
    logic [mept_pkg::USTEP_W-1:0]  r_usteps;
    logic [mept_pkg::GAIN_W-1:0]   r_gain;
    logic [mept_pkg::SAMPLE_W-1:0] r_zoff [mept_pkg::MOTORS];

    logic [mept_pkg::MOTORS-1:0]   r_seeded;
    logic [mept_pkg::MOTORS-1:0]   r_pending;

    logic [mept_pkg::MOT_W-1:0]    r_m;
    logic [mept_pkg::SAMPLE_W-1:0] r_s;
    logic                          r_pend;
    logic signed [mept_pkg::TURN_W-1:0]  r_tc;
    logic [mept_pkg::SPEED_W-1:0]  r_speed;
    logic signed [mept_pkg::POS_W-1:0]   r_pos;
    logic signed [mept_pkg::TPROD_W-1:0] r_tprod;
    logic [mept_pkg::RPM_W-1:0]    r_rpm;
    logic [mept_pkg::ADIFF_W-1:0]  r_adiff;
    logic                          r_rev;
    logic [mept_pkg::PLO_W-1:0]    r_plo;
    logic [mept_pkg::PHI_W-1:0]    r_phi;

    logic                          r_out_valid;
    logic [mept_pkg::MOT_W-1:0]    r_out_m;
    logic signed [mept_pkg::TURN_W-1:0] r_out_tc;
    logic [mept_pkg::SPEED_W-1:0]  r_out_speed;
    logic [mept_pkg::RPM_W-1:0]    r_out_rpm;
    logic                          r_out_mv;
    logic                          r_out_rev;
    logic [mept_pkg::STEPS_W-1:0]  r_out_steps;

    logic                          in_acc;
    logic                          idx_ok;
    logic                          out_free;
    logic                          st_we;
    logic [mept_pkg::MOT_W-1:0]    st_waddr;
    logic [mept_pkg::STATE_W-1:0]  st_wdata;
    logic                          st_re;
    logic [mept_pkg::STATE_W-1:0]  st_rdata;
    logic                          tg_we;
    logic [mept_pkg::TARGET_W-1:0] tg_rdata;
    logic                          seed_set;
    logic                          pend_set;
    logic                          pend_clr;
    logic                          load_out;

    logic [mept_pkg::SAMPLE_W-1:0]       last_s;
    logic signed [mept_pkg::TURN_W-1:0]  tc_old;
    logic signed [mept_pkg::SAMPLE_W:0]  d;
    logic [mept_pkg::SAMPLE_W:0]         mag;
    logic [mept_pkg::SAMPLE_W:0]         mag_w;
    logic                                wrap;
    logic signed [mept_pkg::TURN_W-1:0]  tc_new;
    logic signed [mept_pkg::POS_W-1:0]   pos_new;
    logic signed [mept_pkg::TPROD_W-1:0] tprod_new;
    logic signed [mept_pkg::DIFF_W-1:0]  diff;
    logic [mept_pkg::SPEED_W+mept_pkg::GAIN_W-1:0] rpm_prod;
    logic [mept_pkg::SPEED_W+mept_pkg::GAIN_W-9:0] rpm_q;
    logic [mept_pkg::PSUM_W-1:0]         psum;
    logic [mept_pkg::Q_W-1:0]            q;
    logic [mept_pkg::STEPS_W-1:0]        steps;

    // ------------------------------------------------------------------
    // Handshakes.
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != mept_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == mept_pkg::ST_IDLE);
    assign idx_ok     = (32'(i_motor_index) < 32'(mept_pkg::MOTORS));
    assign out_free   = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear   <= mept_pkg::GEAR_W'(256);
            r_usteps <= mept_pkg::USTEP_W'(3200);
            r_gain   <= mept_pkg::GAIN_W'(75);
            for (int i = 0; i < mept_pkg::MOTORS; i++) begin
                r_zoff[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mept_pkg::CFG_GEAR:     r_gear   <= i_cfg_wr_data;
                mept_pkg::CFG_USTEPS:   r_usteps <= i_cfg_wr_data;
                mept_pkg::CFG_RPM_GAIN: r_gain   <= i_cfg_wr_data[mept_pkg::GAIN_W-1:0];
                mept_pkg::CFG_ZOFF_M0:  r_zoff[0] <= i_cfg_wr_data[mept_pkg::SAMPLE_W-1:0];
                mept_pkg::CFG_ZOFF_M1:  r_zoff[1] <= i_cfg_wr_data[mept_pkg::SAMPLE_W-1:0];
                mept_pkg::CFG_ZOFF_M2:  r_zoff[2] <= i_cfg_wr_data[mept_pkg::SAMPLE_W-1:0];
                mept_pkg::CFG_ZOFF_M3:  r_zoff[3] <= i_cfg_wr_data[mept_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-motor state memories: turn count and last sample, and the target.
    // ------------------------------------------------------------------
    mept_ram #(
        .WIDTH (mept_pkg::STATE_W),
        .DEPTH (mept_pkg::MOTORS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_we),
        .i_wr_addr (st_waddr),
        .i_wr_data (st_wdata),
        .i_rd_en   (st_re),
        .i_rd_addr (i_motor_index),
        .o_rd_data (st_rdata)
    );

    mept_ram #(
        .WIDTH (mept_pkg::TARGET_W),
        .DEPTH (mept_pkg::MOTORS)
    ) u_target_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tg_we),
        .i_wr_addr (i_motor_index),
        .i_wr_data (i_target_position),
        .i_rd_en   (st_re),
        .i_rd_addr (i_motor_index),
        .o_rd_data (tg_rdata)
    );

    // ------------------------------------------------------------------
    // Unwrap arithmetic on the word read back from the state memory.
    // ------------------------------------------------------------------
    always_comb begin
        last_s  = st_rdata[mept_pkg::SAMPLE_W-1:0];
        tc_old  = st_rdata[mept_pkg::STATE_W-1:mept_pkg::SAMPLE_W];
        d       = (mept_pkg::SAMPLE_W+1)'({1'b0, last_s})
                - (mept_pkg::SAMPLE_W+1)'({1'b0, r_s});
        mag     = d[mept_pkg::SAMPLE_W] ? (mept_pkg::SAMPLE_W+1)'(-d)
                                        : (mept_pkg::SAMPLE_W+1)'(d);
        wrap    = (mag > (mept_pkg::SAMPLE_W+1)'(mept_pkg::CPT_HALF));
        mag_w   = wrap ? (mept_pkg::SAMPLE_W+1)'(mept_pkg::CPT) - mag : mag;
        tc_new  = tc_old;
        if (wrap) begin
            if (!d[mept_pkg::SAMPLE_W]) begin
                if (tc_old != 16'sh7FFF) begin
                    tc_new = tc_old + 16'sd1;
                end
            end else begin
                if (tc_old != 16'sh8000) begin
                    tc_new = tc_old - 16'sd1;
                end
            end
        end
        // Motor position in counts, relative to mechanical zero.
        pos_new = (mept_pkg::POS_W'(tc_new) <<< mept_pkg::CPT_LOG2)
                + mept_pkg::POS_W'({1'b0, r_s})
                - mept_pkg::POS_W'({1'b0, r_zoff[r_m]});
        // Target scaled by the gear ratio.
        tprod_new = mept_pkg::TPROD_W'($signed(tg_rdata))
                  * mept_pkg::TPROD_W'($signed({1'b0, r_gear}));
    end

    // Difference, speed scaling and step count assembly.
    always_comb begin
        diff     = (mept_pkg::DIFF_W'(r_pos) <<< 8) - mept_pkg::DIFF_W'(r_tprod);
        rpm_prod = (mept_pkg::SPEED_W+mept_pkg::GAIN_W)'(r_speed)
                 * (mept_pkg::SPEED_W+mept_pkg::GAIN_W)'(r_gain);
        rpm_q    = rpm_prod[mept_pkg::SPEED_W+mept_pkg::GAIN_W-1:8];
        psum     = (mept_pkg::PSUM_W'(r_phi) << mept_pkg::LO_W) + mept_pkg::PSUM_W'(r_plo);
        q        = psum[mept_pkg::PSUM_W-1:mept_pkg::STEP_SHIFT];
        steps    = (|q[mept_pkg::Q_W-1:mept_pkg::STEPS_W]) ? '1
                                                           : q[mept_pkg::STEPS_W-1:0];
    end

    // ------------------------------------------------------------------
    // Sequencer: state register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mept_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and memory controls.
    always_comb begin
        n_state  = r_state;
        st_we    = 1'b0;
        st_waddr = r_m;
        st_wdata = {tc_new, r_s};
        st_re    = 1'b0;
        tg_we    = 1'b0;
        seed_set = 1'b0;
        pend_set = 1'b0;
        pend_clr = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            mept_pkg::ST_IDLE: begin
                if (in_acc && idx_ok) begin
                    if (i_command == mept_pkg::CMD_TARGET) begin
                        tg_we    = 1'b1;
                        pend_set = 1'b1;
                    end else if (!r_seeded[i_motor_index]) begin
                        // First tick: store the sample with a cleared turn count.
                        st_we    = 1'b1;
                        st_waddr = i_motor_index;
                        st_wdata = {mept_pkg::TURN_W'(0), i_encoder_sample};
                        seed_set = 1'b1;
                    end else begin
                        st_re   = 1'b1;
                        n_state = mept_pkg::ST_READ;
                    end
                end
            end
            mept_pkg::ST_READ: begin
                st_we    = 1'b1;
                pend_clr = r_pend;
                n_state  = mept_pkg::ST_DIFF;
            end
            mept_pkg::ST_DIFF: begin
                n_state = r_pend ? mept_pkg::ST_MUL_LO : mept_pkg::ST_OUT;
            end
            mept_pkg::ST_MUL_LO: begin
                n_state = mept_pkg::ST_MUL_HI;
            end
            mept_pkg::ST_MUL_HI: begin
                n_state = mept_pkg::ST_OUT;
            end
            mept_pkg::ST_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = mept_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mept_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Seeded and pending flags.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded  <= '0;
            r_pending <= '0;
        end else begin
            if (seed_set) begin
                r_seeded[i_motor_index] <= 1'b1;
            end
            if (pend_set) begin
                r_pending[i_motor_index] <= 1'b1;
            end else if (pend_clr) begin
                r_pending[r_m] <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_m    <= i_motor_index;
            r_s    <= i_encoder_sample;
            r_pend <= r_pending[i_motor_index];
        end
        if (r_state == mept_pkg::ST_READ) begin
            r_tc    <= tc_new;
            r_speed <= mag_w[mept_pkg::SPEED_W-1:0];
            r_pos   <= pos_new;
            r_tprod <= tprod_new;
        end
        if (r_state == mept_pkg::ST_DIFF) begin
            r_rpm   <= (|rpm_q[mept_pkg::SPEED_W+mept_pkg::GAIN_W-9:mept_pkg::RPM_W])
                       ? '1 : rpm_q[mept_pkg::RPM_W-1:0];
            r_adiff <= diff[mept_pkg::DIFF_W-1] ? mept_pkg::ADIFF_W'(-diff)
                                                : mept_pkg::ADIFF_W'(diff);
            r_rev   <= diff[mept_pkg::DIFF_W-1] || (diff == '0);
        end
        // Step count multiply in two partial products.
        if (r_state == mept_pkg::ST_MUL_LO) begin
            r_plo <= mept_pkg::PLO_W'(r_adiff[mept_pkg::LO_W-1:0])
                   * mept_pkg::PLO_W'(r_usteps);
        end
        if (r_state == mept_pkg::ST_MUL_HI) begin
            r_phi <= mept_pkg::PHI_W'(r_adiff[mept_pkg::ADIFF_W-1:mept_pkg::LO_W])
                   * mept_pkg::PHI_W'(r_usteps);
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_m     <= r_m;
            r_out_tc    <= r_tc;
            r_out_speed <= r_speed;
            r_out_rpm   <= r_rpm;
            r_out_mv    <= r_pend;
            r_out_rev   <= r_pend && r_rev;
            r_out_steps <= r_pend ? steps : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_motor_index_out = r_out_m;
    assign o_turn_count_out  = r_out_tc;
    assign o_speed_counts    = r_out_speed;
    assign o_rpm_estimate    = r_out_rpm;
    assign o_move_valid      = r_out_mv;
    assign o_move_reverse    = r_out_rev;
    assign o_move_steps      = r_out_steps;

endmodule

`default_nettype wire

// ----- tb/mept_tracker_checker.sv -----
// Checker for the multi-turn encoder tracker: predicts each tick result and compares it.
`timescale 1ns / 1ps

module mept_tracker_checker
    import mept_pkg::*;
(
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input channel, observed.
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic                           i_command,
    input  wire logic [MOT_W-1:0]               i_motor_index,
    input  wire logic [SAMPLE_W-1:0]            i_encoder_sample,
    input  wire logic signed [TARGET_W-1:0]     i_target_position,
    // Output channel, observed.
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [MOT_W-1:0]               i_motor_index_out,
    input  wire logic signed [TURN_W-1:0]       i_turn_count_out,
    input  wire logic [SPEED_W-1:0]             i_speed_counts,
    input  wire logic [RPM_W-1:0]               i_rpm_estimate,
    input  wire logic                           i_move_valid,
    input  wire logic                           i_move_reverse,
    input  wire logic [STEPS_W-1:0]             i_move_steps,
    // Configuration port, observed.
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          i_cfg_wr_data,
    // Status handed to the testbench top.
    output int                                  o_fail_count,
    output int                                  o_outstanding,
    output int                                  o_checked_count
);

    localparam int GEAR_RESET   = 256;
    localparam int USTEPS_RESET = 3200;
    localparam int GAIN_RESET   = 75;
    localparam int TURN_MAX     = (1 << (TURN_W - 1)) - 1;
    localparam int TURN_MIN     = -(1 << (TURN_W - 1));
    localparam int SPEED_MAX    = (1 << SPEED_W) - 1;
    localparam int RPM_MAX      = (1 << RPM_W) - 1;
    localparam longint unsigned STEPS_MAX = (1 << STEPS_W) - 1;
    localparam int REPORT_LIMIT = 40;

    // One tick result as the block should present it.
    typedef struct {
        logic [MOT_W-1:0]         motor;
        logic signed [TURN_W-1:0] turns;
        logic [SPEED_W-1:0]       speed;
        logic [RPM_W-1:0]         rpm;
        logic                     move_valid;
        logic                     move_reverse;
        logic [STEPS_W-1:0]       steps;
    } t_tick_result;

    t_tick_result             expected_ticks[$];

    // Shadow of the registers.
    logic [GEAR_W-1:0]        gear_q8;
    logic [USTEP_W-1:0]       usteps;
    logic [GAIN_W-1:0]        rpm_gain;
    logic [SAMPLE_W-1:0]      zero_offset[MOTORS];

    // Shadow of the per-motor tracking state.
    logic [SAMPLE_W-1:0]      last_reading[MOTORS];
    bit                       seeded[MOTORS];
    logic signed [TURN_W-1:0] turns_acc[MOTORS];
    logic signed [TARGET_W-1:0] target_held[MOTORS];
    bit                       target_armed[MOTORS];

    int                       mismatches = 0;
    int                       checked = 0;
    int                       outstanding = 0;

    assign o_fail_count    = mismatches;
    assign o_outstanding   = outstanding;
    assign o_checked_count = checked;

    // Print one line per mismatch, up to a limit, and count every one.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < REPORT_LIMIT) begin
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Return the shadow state to its reset values.
    task automatic reset_tracker_model();
        gear_q8  = GEAR_RESET;
        usteps   = USTEPS_RESET;
        rpm_gain = GAIN_RESET;
        for (int m = 0; m < MOTORS; m++) begin
            zero_offset[m]  = '0;
            last_reading[m] = '0;
            seeded[m]       = 1'b0;
            turns_acc[m]    = '0;
            target_held[m]  = '0;
            target_armed[m] = 1'b0;
        end
        expected_ticks.delete();
    endtask

    // A write to an index outside the register list changes nothing.
    task automatic apply_register_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GEAR:     gear_q8 = data[GEAR_W-1:0];
            CFG_USTEPS:   usteps = data[USTEP_W-1:0];
            CFG_RPM_GAIN: rpm_gain = data[GAIN_W-1:0];
            CFG_ZOFF_M0:  zero_offset[0] = data[SAMPLE_W-1:0];
            CFG_ZOFF_M1:  zero_offset[1] = data[SAMPLE_W-1:0];
            CFG_ZOFF_M2:  zero_offset[2] = data[SAMPLE_W-1:0];
            CFG_ZOFF_M3:  zero_offset[3] = data[SAMPLE_W-1:0];
            default: ;
        endcase
    endtask

    // Unwrap one encoder reading and work out the tick result, if any.
    task automatic predict_tick(input logic [MOT_W-1:0] m, input logic [SAMPLE_W-1:0] s);
        int                  d;
        int                  mag;
        int                  tc;
        int                  rpm;
        longint              pos;
        longint              diff;
        longint unsigned     adiff;
        longint unsigned     steps;
        t_tick_result        r;
        if (!seeded[m]) begin
            // The first reading only seeds the motor; a pending target waits.
            last_reading[m] = s;
            seeded[m] = 1'b1;
        end else begin
            d   = int'(last_reading[m]) - int'(s);
            mag = (d < 0) ? -d : d;
            tc  = int'(turns_acc[m]);
            // More than half a turn is a wrap through zero; exactly half is not.
            if (mag > CPT_HALF) begin
                mag = CPT - mag;
                if (d >= 0) begin
                    if (tc < TURN_MAX) tc++;
                end else begin
                    if (tc > TURN_MIN) tc--;
                end
            end
            turns_acc[m]    = tc[TURN_W-1:0];
            last_reading[m] = s;

            if (mag > SPEED_MAX) mag = SPEED_MAX;
            rpm = (mag * int'(rpm_gain)) / 256;
            if (rpm > RPM_MAX) rpm = RPM_MAX;

            r.motor        = m;
            r.turns        = tc[TURN_W-1:0];
            r.speed        = mag[SPEED_W-1:0];
            r.rpm          = rpm[RPM_W-1:0];
            r.move_valid   = 1'b0;
            r.move_reverse = 1'b0;
            r.steps        = '0;

            // A pending target turns into a move command and is then cleared.
            if (target_armed[m]) begin
                pos   = longint'(s) + longint'(tc) * CPT - longint'(zero_offset[m]);
                diff  = pos * 256 - longint'(target_held[m]) * longint'(gear_q8);
                adiff = (diff < 0) ? longint'(-diff) : longint'(diff);
                steps = adiff * longint'(usteps) / (longint'(CPT) * 256);
                if (steps > STEPS_MAX) steps = STEPS_MAX;
                r.move_valid   = 1'b1;
                r.move_reverse = (diff <= 0);
                r.steps        = steps[STEPS_W-1:0];
                target_armed[m] = 1'b0;
            end
            expected_ticks.push_back(r);
        end
    endtask

    // Compare one delivered result with the oldest expectation.
    task automatic check_result();
        t_tick_result want;
        if (expected_ticks.size() == 0) begin
            report_mismatch("result word with nothing expected, motor",
                            longint'(i_motor_index_out), -1);
        end else begin
            want = expected_ticks.pop_front();
            checked++;
            if (i_motor_index_out !== want.motor)
                report_mismatch("motor_index_out", i_motor_index_out, want.motor);
            if (i_turn_count_out !== want.turns)
                report_mismatch("turn_count_out", i_turn_count_out, want.turns);
            if (i_speed_counts !== want.speed)
                report_mismatch("speed_counts", i_speed_counts, want.speed);
            if (i_rpm_estimate !== want.rpm)
                report_mismatch("rpm_estimate", i_rpm_estimate, want.rpm);
            if (i_move_valid !== want.move_valid)
                report_mismatch("move_valid", i_move_valid, want.move_valid);
            if (i_move_reverse !== want.move_reverse)
                report_mismatch("move_reverse", i_move_reverse, want.move_reverse);
            if (i_move_steps !== want.steps)
                report_mismatch("move_steps", i_move_steps, want.steps);
        end
    endtask

    // Watch all three ports at each rising edge; results leave before new words predict.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_tracker_model();
        end else begin
            if (i_cfg_wr_en) begin
                apply_register_write(i_cfg_index, i_cfg_wr_data);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_command == CMD_TARGET) begin
                    target_held[i_motor_index]  = i_target_position;
                    target_armed[i_motor_index] = 1'b1;
                end else begin
                    predict_tick(i_motor_index, i_encoder_sample);
                end
            end
        end
        outstanding <= expected_ticks.size();
    end

endmodule

// ----- tb/tb_multiturn_encoder_position_tracker_core.sv -----
// Testbench top for the multi-turn encoder tracker: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_multiturn_encoder_position_tracker_core;
    import mept_pkg::*;

    localparam int     CYCLE_LIMIT   = 5_000_000;
    localparam int     SETTLE_CYCLES = 10;
    localparam int     SWEEP_TICKS   = 16;
    localparam int     SWEEP_STRIDE  = CPT_HALF - 1;
    localparam int     RANDOM_PHASES = 6;
    localparam int     PHASE_WORDS   = 215;
    localparam longint TARGET_MAX    = (longint'(1) << (TARGET_W - 1)) - 1;
    localparam longint TARGET_MIN    = -(longint'(1) << (TARGET_W - 1));
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    // Clock, reset and block inputs, all known from time zero.
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic                           i_command = CMD_TICK;
    logic [MOT_W-1:0]               i_motor_index = '0;
    logic [SAMPLE_W-1:0]            i_encoder_sample = '0;
    logic signed [TARGET_W-1:0]     i_target_position = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [MOT_W-1:0]               o_motor_index_out;
    logic signed [TURN_W-1:0]       o_turn_count_out;
    logic [SPEED_W-1:0]             o_speed_counts;
    logic [RPM_W-1:0]               o_rpm_estimate;
    logic                           o_move_valid;
    logic                           o_move_reverse;
    logic [STEPS_W-1:0]             o_move_steps;
    logic                           i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]           i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]          i_cfg_wr_data = '0;

    int                             fail_count;
    int                             outstanding;
    int                             checked_count;

    // Stimulus bookkeeping: idling, back-pressure, the cycle guard, word counts and motor positions.
    bit                             idling_on = 1'b1;
    int                             stall_left = 0;
    int                             cycle_count = 0;
    int                             words_sent = 0;
    int                             sweep_words = 0;
    int                             settings_loaded = 0;
    bit                             motor_seen[MOTORS];
    logic [SAMPLE_W-1:0]            last_sent[MOTORS];
    longint                         pos_est[MOTORS];
    logic [GEAR_W-1:0]              gear_now = 16'd256;
    logic [SAMPLE_W-1:0]            zoff_now[MOTORS];

    multiturn_encoder_position_tracker_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_motor_index      (i_motor_index),
        .i_encoder_sample   (i_encoder_sample),
        .i_target_position  (i_target_position),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_motor_index_out  (o_motor_index_out),
        .o_turn_count_out   (o_turn_count_out),
        .o_speed_counts     (o_speed_counts),
        .o_rpm_estimate     (o_rpm_estimate),
        .o_move_valid       (o_move_valid),
        .o_move_reverse     (o_move_reverse),
        .o_move_steps       (o_move_steps),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wr_data      (i_cfg_wr_data)
    );

    mept_tracker_checker i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_motor_index      (i_motor_index),
        .i_encoder_sample   (i_encoder_sample),
        .i_target_position  (i_target_position),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_motor_index_out  (o_motor_index_out),
        .i_turn_count_out   (o_turn_count_out),
        .i_speed_counts     (o_speed_counts),
        .i_rpm_estimate     (o_rpm_estimate),
        .i_move_valid       (o_move_valid),
        .i_move_reverse     (o_move_reverse),
        .i_move_steps       (o_move_steps),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .o_fail_count       (fail_count),
        .o_outstanding      (outstanding),
        .o_checked_count    (checked_count)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multiturn_encoder_position_tracker_core: mismatch");
            $finish;
        end
    end

    // Output back-pressure in random bursts, started only while idling is on.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left  <= $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Offer one word, with an optional idle burst first, and wait until it is taken.
    task automatic send_word(input t_cmd cmd, input logic [MOT_W-1:0] m,
                             input logic [SAMPLE_W-1:0] s,
                             input logic signed [TARGET_W-1:0] t);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_command         <= cmd;
        i_motor_index     <= m;
        i_encoder_sample  <= s;
        i_target_position <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // Send a tick and keep a rough unwrapped position for target shaping.
    task automatic send_tick(input logic [MOT_W-1:0] m, input logic [SAMPLE_W-1:0] s);
        int          step;
        logic [31:0] noise;
        noise = $urandom;
        if (!motor_seen[m]) begin
            pos_est[m]    = s;
            motor_seen[m] = 1'b1;
        end else begin
            step = int'(s) - int'(last_sent[m]);
            if (step > CPT_HALF) step -= CPT;
            else if (step < -CPT_HALF) step += CPT;
            pos_est[m] += step;
        end
        last_sent[m] = s;
        send_word(CMD_TICK, m, s, noise[TARGET_W-1:0]);
    endtask

    task automatic send_target(input logic [MOT_W-1:0] m, input longint t);
        logic [31:0] noise;
        noise = $urandom;
        send_word(CMD_TARGET, m, noise[SAMPLE_W-1:0], t[TARGET_W-1:0]);
    endtask

    // Mostly targets a few turns from the motor, some anywhere, a few at the limits.
    function automatic longint pick_target(input int m);
        int          r;
        longint      t;
        logic [31:0] raw;
        r   = $urandom_range(0, 99);
        raw = $urandom;
        if (r < 60 && gear_now != 0) begin
            t = ((pos_est[m] - longint'(zoff_now[m])) * 256) / longint'(gear_now)
                + longint'($urandom_range(0, 32768)) - 16384;
        end else if (r < 88) begin
            t = longint'($signed(raw[TARGET_W-1:0]));
        end else if (r < 94) begin
            t = TARGET_MAX;
        end else begin
            t = TARGET_MIN;
        end
        if (t > TARGET_MAX) t = TARGET_MAX;
        if (t < TARGET_MIN) t = TARGET_MIN;
        return t;
    endfunction

    // Small moves, free moves with wraps, exact half turns, the edges of half a turn and no move.
    task automatic send_random_tick(input logic [MOT_W-1:0] m);
        int r;
        int delta;
        r = $urandom_range(0, 99);
        if (r < 35) delta = int'($urandom_range(0, 126)) - 63;
        else if (r < 65) delta = $urandom_range(0, CPT - 1);
        else if (r < 77) delta = ($urandom_range(0, 1) != 0) ? CPT_HALF : -CPT_HALF;
        else if (r < 90) delta = (int'($urandom_range(0, 16)) - 8 + CPT_HALF)
                                 * (($urandom_range(0, 1) != 0) ? 1 : -1);
        else delta = 0;
        send_tick(m, last_sent[m] + delta[SAMPLE_W-1:0]);
    endtask

    // Stop offering words, let every result drain, then give the block time to settle.
    task automatic drain_tracker();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
    endtask

    // Write every register, plus the unused index, while the block is idle.
    task automatic load_settings(input logic [GEAR_W-1:0] gear, input logic [USTEP_W-1:0] ust,
                                 input logic [GAIN_W-1:0] gain,
                                 input logic [SAMPLE_W-1:0] z0, input logic [SAMPLE_W-1:0] z1,
                                 input logic [SAMPLE_W-1:0] z2, input logic [SAMPLE_W-1:0] z3);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_GEAR, gear);
        write_reg(CFG_USTEPS, ust);
        write_reg(CFG_RPM_GAIN, gain);
        write_reg(CFG_ZOFF_M0, z0);
        write_reg(CFG_ZOFF_M1, z1);
        write_reg(CFG_ZOFF_M2, z2);
        write_reg(CFG_ZOFF_M3, z3);
        write_reg(CFG_IDX_SPARE, junk[CFG_DATA_W-1:0]);
        i_cfg_wr_en <= 1'b0;
        gear_now    = gear;
        zoff_now[0] = z0;
        zoff_now[1] = z1;
        zoff_now[2] = z2;
        zoff_now[3] = z3;
        settings_loaded++;
    endtask

    function automatic logic [15:0] pick_wide_setting();
        case ($urandom_range(0, 3))
            0:       return 16'd1;
            1:       return 16'd256;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // Walk one motor by just under half a turn per tick, so its turn count steps every other tick.
    task automatic sweep_turns(input logic [MOT_W-1:0] m, input int stride);
        for (int i = 0; i < SWEEP_TICKS; i++) begin
            send_tick(m, last_sent[m] + stride[SAMPLE_W-1:0]);
            sweep_words++;
        end
    endtask

    initial begin
        for (int m = 0; m < MOTORS; m++) begin
            motor_seen[m] = 1'b0;
            last_sent[m]  = '0;
            pos_est[m]    = 0;
            zoff_now[m]   = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: pending target across the seeding tick, a tick that uses it, then a plain tick.
        send_target(1, 5000);
        send_tick(1, 12'd100);
        send_tick(1, 12'd150);
        send_tick(1, 12'd200);
        // Exact half turns in both directions do not wrap; one count more does, as does a single count across zero.
        send_tick(0, 12'd0);
        send_tick(0, 12'd2048);
        send_tick(0, 12'd0);
        send_tick(0, 12'd4095);
        send_tick(0, 12'd0);
        send_tick(0, 12'd2049);
        send_tick(0, 12'd0);
        // Extreme targets saturate the step count; a target equal to the position is reverse.
        send_target(0, TARGET_MAX);
        send_tick(0, 12'd4095);
        send_target(0, TARGET_MIN);
        send_tick(0, 12'd0);
        send_target(0, 0);
        send_tick(0, 12'd0);
        send_tick(3, 12'd4095);
        send_tick(3, 12'd4095);
        send_tick(2, 12'hAAA);
        send_tick(2, 12'h555);
        drain_tracker();

        // Zero gear, zero microsteps and zero gain, with full zero offsets.
        load_settings(16'd0, 16'd0, 9'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_target(0, 12345);
        send_tick(0, 12'd100);
        send_target(1, TARGET_MAX);
        send_tick(1, last_sent[1] + 12'd2048);
        drain_tracker();

        // Full-scale gear, microsteps and gain.
        load_settings(16'hFFFF, 16'hFFFF, 9'h1FF, 12'd0, 12'hFFF, 12'd1, 12'd2048);
        send_target(1, TARGET_MIN);
        send_tick(1, last_sent[1] + 12'd2048);
        send_target(2, TARGET_MAX);
        send_tick(2, last_sent[2] + 12'd1);
        drain_tracker();

        // Step one motor up through several turns and another down.
        idling_on = 1'b0;
        sweep_turns(2, SWEEP_STRIDE);
        sweep_turns(3, -SWEEP_STRIDE);
        send_target(2, pick_target(2));
        send_tick(2, last_sent[2] + 12'(SWEEP_STRIDE));
        send_target(3, pick_target(3));
        send_tick(3, last_sent[3] - 12'(SWEEP_STRIDE));
        drain_tracker();

        // Random phases, each under fresh settings; the last one runs without idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_settings(pick_wide_setting(), pick_wide_setting(),
                          9'($urandom_range(0, 511)),
                          12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                          12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            idling_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 4) != 0);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_target(2'($urandom_range(0, MOTORS - 1)),
                                pick_target(2'($urandom_range(0, MOTORS - 1))));
                end else begin
                    send_random_tick(2'($urandom_range(0, MOTORS - 1)));
                end
            end
            drain_tracker();
        end

        $display("Run sent %0d input words, %0d of them in two turn sweeps; %0d results checked.",
                 words_sent, sweep_words, checked_count);
        $display("%0d register settings loaded, including zero and full-scale gear, microsteps and gain.",
                 settings_loaded);
        if (fail_count == 0) begin
            $display("multiturn_encoder_position_tracker_core: match");
        end else begin
            $display("multiturn_encoder_position_tracker_core: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mept_pkg.sv
hw/rtl/mept_ram.sv
hw/rtl/multiturn_encoder_position_tracker_core.sv
tb/mept_tracker_checker.sv
tb/tb_multiturn_encoder_position_tracker_core.sv
